[sv/gdb_pkg.sv]
// Shared types, constants and calendar helpers for the Gregorian days-between block.
// Used by gdb_ctrl, gdb_datapath and gregorian_days_between_core; no dependencies.
package gdb_pkg;

    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int COUNT_W     = 22;
    localparam int DOY_W       = 9;
    localparam int MAX_YEAR_DEF = 9999;
    localparam int COUNT_MAX   = 4194303;
    localparam int DAYS_YEAR   = 365;
    localparam int DAYS_LEAP   = 366;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } t_gdb_in;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               order_invalid;
    } t_gdb_out;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic calc;
        logic out_load;
    } t_gdb_cmd;

    // datapath -> controller
    typedef struct packed {
        logic early;
        logic at_end;
    } t_gdb_sts;

    // days in all earlier months of a common year; months 13..15 are February-long
    function automatic logic [DOY_W-1:0] cum_days(logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] c;
        unique case (m)
            4'd0:  c = 9'd0;
            4'd1:  c = 9'd0;
            4'd2:  c = 9'd31;
            4'd3:  c = 9'd59;
            4'd4:  c = 9'd90;
            4'd5:  c = 9'd120;
            4'd6:  c = 9'd151;
            4'd7:  c = 9'd181;
            4'd8:  c = 9'd212;
            4'd9:  c = 9'd243;
            4'd10: c = 9'd273;
            4'd11: c = 9'd304;
            4'd12: c = 9'd334;
            4'd13: c = 9'd365;
            4'd14: c = 9'd393;
            4'd15: c = 9'd421;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // number of February-long months before month m (each gains a day in a leap year)
    function automatic logic [1:0] feb_count(logic [MONTH_W-1:0] m);
        logic [1:0] f;
        if (m <= 4'd2) begin
            f = 2'd0;
        end else if (m <= 4'd13) begin
            f = 2'd1;
        end else if (m == 4'd14) begin
            f = 2'd2;
        end else begin
            f = 2'd3;
        end
        return f;
    endfunction

    function automatic logic [DOY_W-1:0] day_num(logic [MONTH_W-1:0] m,
                                                 logic [DAY_W-1:0] d, logic leap);
        logic [DOY_W-1:0] extra;
        extra = leap ? DOY_W'(feb_count(m)) : '0;
        return DOY_W'(d) + cum_days(m) + extra;
    endfunction

endpackage

[sv/gdb_ctrl.sv]
// Sequencer for the Gregorian days-between block: request intake, year walk, result handoff.
// Depends on gdb_pkg for the command and status structs.
module gdb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  gdb_pkg::t_gdb_sts i_sts,
    output gdb_pkg::t_gdb_cmd o_cmd
);
    import gdb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_CALC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                // skip the year walk when the dates are out of order
                if (!i_sts.early) begin
                    n_state = S_CALC;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.at_end) begin
                        n_state = S_CALC;
                    end
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[sv/gdb_datapath.sv]
// Datapath for the Gregorian days-between block: year clamp, order check, year walk
// with running mod-4/100/400 counters, final day arithmetic and output register.
// Depends on gdb_pkg.
module gdb_datapath #(
    parameter int MAX_YEAR = gdb_pkg::MAX_YEAR_DEF
) (
    input  logic              i_clk,
    input  gdb_pkg::t_gdb_in  i_in,
    input  gdb_pkg::t_gdb_cmd i_cmd,
    output gdb_pkg::t_gdb_sts o_sts,
    output gdb_pkg::t_gdb_out o_out
);
    import gdb_pkg::*;

    localparam int YW = $clog2(MAX_YEAR + 1);
    localparam int AW = $clog2(DAYS_LEAP * (MAX_YEAR + 1));
    localparam int NW = ((AW > COUNT_W + 1) ? AW : COUNT_W + 1) + 2;

    function automatic logic [YW-1:0] clamp_year(logic [YEAR_W-1:0] y);
        logic [YW-1:0] c;
        if (32'(y) > 32'(MAX_YEAR)) begin
            c = YW'(MAX_YEAR);
        end else begin
            c = YW'(y);
        end
        return c;
    endfunction

    logic [YW-1:0]      w_sy, w_ey;
    logic               w_early;
    logic               w_leap;
    logic [DOY_W-1:0]   w_dn_s, w_dn_e;
    logic [DOY_W-1:0]   w_base;
    logic [NW-1:0]      w_n;

    logic [YW-1:0]      r_sy, r_ey, r_yc;
    logic [MONTH_W-1:0] r_sm, r_em;
    logic [DAY_W-1:0]   r_sd, r_ed;
    logic               r_early;
    logic [1:0]         r_m4;
    logic [6:0]         r_m100;
    logic [8:0]         r_m400;
    logic [AW-1:0]      r_acc;
    logic               r_leap_s, r_leap_e;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_inv;
    t_gdb_out           r_out;

    assign w_sy = clamp_year(i_in.start_year);
    assign w_ey = clamp_year(i_in.end_year);
    assign w_early = (w_sy < w_ey) ||
                     ((w_sy == w_ey) && ((i_in.start_month < i_in.end_month) ||
                      ((i_in.start_month == i_in.end_month) &&
                       (i_in.start_day <= i_in.end_day))));

    assign w_leap = (r_m4 == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));

    assign w_dn_s = day_num(r_sm, r_sd, r_leap_s);
    assign w_dn_e = day_num(r_em, r_ed, r_leap_e);
    assign w_base = r_leap_s ? DOY_W'(DAYS_LEAP) : DOY_W'(DAYS_YEAR);

    always_comb begin
        if (r_ey != r_sy) begin
            w_n = NW'(w_base) - NW'(w_dn_s) + NW'(w_dn_e) + NW'(r_acc);
        end else begin
            w_n = NW'(w_dn_e) - NW'(w_dn_s);
        end
    end

    assign o_sts.early  = r_early;
    assign o_sts.at_end = (r_yc == r_ey);
    assign o_out        = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sy    <= w_sy;
            r_ey    <= w_ey;
            r_sm    <= i_in.start_month;
            r_sd    <= i_in.start_day;
            r_em    <= i_in.end_month;
            r_ed    <= i_in.end_day;
            r_early <= w_early;
            r_yc    <= '0;
            r_m4    <= '0;
            r_m100  <= '0;
            r_m400  <= '0;
            r_acc   <= '0;
        end else if (i_cmd.step) begin
            // walk one year; pick up leap flags of both end years on the way
            if (r_yc == r_sy) begin
                r_leap_s <= w_leap;
            end
            if (r_yc == r_ey) begin
                r_leap_e <= w_leap;
            end
            if ((r_yc > r_sy) && (r_yc < r_ey)) begin
                r_acc <= r_acc + (w_leap ? AW'(DAYS_LEAP) : AW'(DAYS_YEAR));
            end
            if (r_yc != r_ey) begin
                r_yc   <= r_yc + 1'b1;
                r_m4   <= r_m4 + 1'b1;
                r_m100 <= (r_m100 == 7'd99) ? 7'd0 : r_m100 + 1'b1;
                r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 1'b1;
            end
        end

        if (i_cmd.calc) begin
            if (!r_early) begin
                r_cnt <= '0;
                r_inv <= 1'b1;
            end else begin
                r_inv <= 1'b0;
                if (w_n[NW-1]) begin
                    r_cnt <= '0;
                end else if (w_n > NW'(COUNT_MAX)) begin
                    r_cnt <= COUNT_W'(COUNT_MAX);
                end else begin
                    r_cnt <= w_n[COUNT_W-1:0];
                end
            end
        end

        if (i_cmd.out_load) begin
            r_out.day_count     <= r_cnt;
            r_out.order_invalid <= r_inv;
        end
    end

endmodule

[sv/gregorian_days_between_core.sv]
// Gregorian days-between core: takes two dates and returns the day count from the first
// to the second, or order_invalid with a zero count when the first is later. Years above
// MAX_YEAR are clamped; unchecked days and months pass through the arithmetic and the count
// saturates to 0 and 4194303. One request is worked at a time by a year-walking loop that
// steps one year per clock from year 0 up to the clamped end year; an out-of-order request
// skips the walk, and the next request is taken only once the result has been loaded into
// the output register. The result sits in that register, so the next request is accepted
// while it still waits to be taken.
// Depends on gdb_pkg, gdb_ctrl and gdb_datapath.
module gregorian_days_between_core #(
    parameter int MAX_YEAR = gdb_pkg::MAX_YEAR_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gdb_pkg::t_gdb_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gdb_pkg::t_gdb_out o_out
);
    import gdb_pkg::*;

    t_gdb_cmd w_cmd;
    t_gdb_sts w_sts;

    gdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    gdb_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .i_clk (i_clk),
        .i_in  (i_in),
        .i_cmd (w_cmd),
        .o_sts (w_sts),
        .o_out (o_out)
    );

endmodule

[verif/tb.sv]
// Testbench for gregorian_days_between_core: directed and random date pairs, each result
// checked against a calendar predictor built here. Depends on gdb_pkg and the core RTL.
module tb;
    import gdb_pkg::*;

    localparam int IDLE_LIMIT = 40000;
    localparam int LONG_HOLD  = 60;
    localparam int TAIL_WAIT  = 20;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     out_stall = 1'b0;
    t_gdb_in  in_req = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_gdb_out o_out;

    t_gdb_in  date_pairs_q[$];
    t_gdb_out expected_counts[$];
    int       items_queued = 0;
    int       items_sent = 0;
    int       results_seen = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       all_queued = 1'b0;
    logic     calm = 1'b0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    bit       long_hold_done = 1'b0;

    gregorian_days_between_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_leap(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // months 13..15 fall in the default arm and count as February
    function automatic int day_of_year(int y, int m, int d);
        int n;
        int i;
        n = d;
        for (i = 1; i < m; i++) begin
            case (i)
                4, 6, 9, 11: n += 30;
                1, 3, 5, 7, 8, 10, 12: n += 31;
                default: n += is_leap(y) ? 29 : 28;
            endcase
        end
        return n;
    endfunction

    function automatic int leaps_through(int y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic t_gdb_out days_between(t_gdb_in p);
        int       sy;
        int       ey;
        bit       in_order;
        longint   n;
        t_gdb_out r;
        sy = (p.start_year > MAX_YEAR_DEF) ? MAX_YEAR_DEF : int'(p.start_year);
        ey = (p.end_year > MAX_YEAR_DEF) ? MAX_YEAR_DEF : int'(p.end_year);
        if (sy != ey) begin
            in_order = sy < ey;
        end else if (p.start_month != p.end_month) begin
            in_order = p.start_month < p.end_month;
        end else begin
            in_order = p.start_day <= p.end_day;
        end
        r.order_invalid = !in_order;
        r.day_count = '0;
        if (in_order) begin
            if (sy != ey) begin
                n = (is_leap(sy) ? DAYS_LEAP : DAYS_YEAR)
                    - day_of_year(sy, p.start_month, p.start_day)
                    + day_of_year(ey, p.end_month, p.end_day)
                    + longint'(DAYS_YEAR) * (ey - 1 - sy)
                    + leaps_through(ey - 1) - leaps_through(sy);
            end else begin
                n = day_of_year(ey, p.end_month, p.end_day)
                    - day_of_year(sy, p.start_month, p.start_day);
            end
            if (n < 0) n = 0;
            if (n > COUNT_MAX) n = COUNT_MAX;
            r.day_count = n[COUNT_W-1:0];
        end
        return r;
    endfunction

    function automatic t_gdb_in dates(int sy, int sm, int sd, int ey, int em, int ed);
        t_gdb_in r;
        r.start_year  = sy[YEAR_W-1:0];
        r.start_month = sm[MONTH_W-1:0];
        r.start_day   = sd[DAY_W-1:0];
        r.end_year    = ey[YEAR_W-1:0];
        r.end_month   = em[MONTH_W-1:0];
        r.end_day     = ed[DAY_W-1:0];
        return r;
    endfunction

    task automatic queue_request(t_gdb_in p);
        date_pairs_q.push_back(p);
        items_queued++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        calm <= all_queued && (date_pairs_q.size() < 20);
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_counts.push_back(days_between(in_req));
                items_sent++;
            end
            // hold a stalled request
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (date_pairs_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    in_valid <= 1'b0;
                    gap_left <= $urandom_range(0, 3);
                end else begin
                    in_valid <= 1'b1;
                    in_req   <= date_pairs_q.pop_front();
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        t_gdb_out want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                results_seen++;
                if (expected_counts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: count %0d invalid %0b",
                                 o_out.day_count, o_out.order_invalid);
                end else begin
                    want = expected_counts.pop_front();
                    if (o_out.day_count !== want.day_count
                        || o_out.order_invalid !== want.order_invalid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want %0d/%0b got %0d/%0b",
                                     want.day_count, want.order_invalid,
                                     o_out.day_count, o_out.order_invalid);
                    end
                end
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!long_hold_done && results_seen >= 1) begin
                // long hold over the short wrong-order requests so the core backs up
                out_stall      <= 1'b1;
                hold_left      <= LONG_HOLD - 1;
                long_hold_done <= 1'b1;
            end else if (stall_left > 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int k;
        int sel;
        int sy;
        int ey;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_request(dates(2000, 1, 1, 2000, 1, 1));        // equal dates
        queue_request(dates(2001, 3, 1, 2000, 3, 1));        // wrong order by year
        queue_request(dates(2000, 5, 1, 2000, 4, 30));       // wrong order by month
        queue_request(dates(2000, 5, 10, 2000, 5, 9));       // wrong order by day
        queue_request(dates(2000, 1, 1, 2000, 12, 31));
        queue_request(dates(1900, 2, 28, 1900, 3, 1));       // century, not leap
        queue_request(dates(0, 1, 1, 4, 1, 1));              // year zero is leap
        queue_request(dates(1999, 12, 31, 2000, 1, 1));
        queue_request(dates(100, 2, 31, 100, 3, 1));         // day past month end
        queue_request(dates(50, 0, 31, 50, 1, 0));           // negative, same year
        queue_request(dates(0, 15, 31, 1, 0, 0));            // negative across years
        queue_request(dates(10, 13, 1, 10, 14, 5));          // months above twelve
        queue_request(dates(10, 0, 0, 10, 15, 31));
        queue_request(dates(16383, 15, 31, 9999, 1, 1));     // clamped start, wrong order
        queue_request(dates(9999, 12, 31, 16383, 1, 1));     // clamped end, wrong order
        queue_request(dates(12000, 6, 1, 15000, 6, 1));      // both clamp to equal
        queue_request(dates(1600, 2, 29, 2400, 2, 29));
        queue_request(dates(0, 1, 1, 9999, 12, 31));
        queue_request(dates(0, 0, 0, 16383, 15, 31));

        // wait until the directed set has drained before queuing the random set
        while (items_sent != items_queued || expected_counts.size() != 0) @(posedge i_clk);

        for (k = 0; k < 81; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                sy = $urandom_range(0, 9999);
                ey = $urandom_range(sy, 16383);
                queue_request(dates(sy, $urandom_range(1, 12), $urandom_range(1, 31),
                                    ey, $urandom_range(1, 12), $urandom_range(1, 31)));
            end else if (sel < 22) begin
                // noise: any field value, mostly wrong order
                sy = $urandom_range(0, 16383);
                ey = $urandom_range(0, sy);
                queue_request(dates(sy, $urandom_range(0, 15), $urandom_range(0, 31),
                                    ey, $urandom_range(0, 15), $urandom_range(0, 31)));
            end else begin
                sy = $urandom_range(0, 250);
                ey = sy + $urandom_range(0, 40);
                queue_request(dates(sy, $urandom_range(1, 12), $urandom_range(1, 31),
                                    ey, $urandom_range(1, 12), $urandom_range(1, 31)));
            end
        end
        all_queued = 1'b1;

        while (items_sent != items_queued || expected_counts.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0 && expected_counts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
